FILE: design/mrt_pkg.sv
package mrt_pkg;
	localparam int SLOT_COUNT = 16;
	localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PAGE_BITS  = 12;
	localparam int FILE_SLOTS = 16;
	localparam int ADDR_W     = 38;
	localparam int LEN_W      = 31;

	localparam logic [1:0] OP_MAP   = 2'd0;
	localparam logic [1:0] OP_FIND  = 2'd1;
	localparam logic [1:0] OP_UNMAP = 2'd2;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_BAD_ARG   = 4'd1;
	localparam logic [3:0] ST_NO_FILE   = 4'd2;
	localparam logic [3:0] ST_NOT_WR    = 4'd3;
	localparam logic [3:0] ST_EXEC      = 4'd4;
	localparam logic [3:0] ST_NO_MODE   = 4'd5;
	localparam logic [3:0] ST_FULL      = 4'd6;
	localparam logic [3:0] ST_NO_SPACE  = 4'd7;
	localparam logic [3:0] ST_NOT_FOUND = 4'd8;
	localparam logic [3:0] ST_MIDDLE    = 4'd9;

	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef struct packed {
		logic clear;     // load request, reset scan trackers
		logic scan;      // examine slot scan_idx
		logic finish;    // form result, update table
	} mrt_cmd_t;

	typedef struct packed {
		logic precheck_fail;
	} mrt_stat_t;
endpackage

FILE: design/mrt_ctrl.sv
module mrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mrt_pkg::mrt_stat_t stat,
	output mrt_pkg::mrt_cmd_t  cmd,
	output logic [mrt_pkg::SLOT_BITS-1:0] scan_idx
);
	import mrt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [SLOT_BITS-1:0] idx_q;

	assign busy     = (state_q != S_IDLE);
	assign scan_idx = idx_q;

	always_comb begin
		cmd.clear  = (state_q == S_IDLE) && start;
		cmd.scan   = (state_q == S_SCAN);
		cmd.finish = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_LOAD;
					idx_q <= '0;
				end
				S_LOAD: begin
					if (stat.precheck_fail) state_q <= S_DONE;
					else state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (idx_q == SLOT_BITS'(SLOT_COUNT - 1)) state_q <= S_DONE;
					else idx_q <= idx_q + 1'b1;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/mrt_dp.sv
module mrt_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mrt_pkg::mrt_cmd_t  cmd,
	output mrt_pkg::mrt_stat_t stat,
	input  logic [mrt_pkg::SLOT_BITS-1:0] scan_idx,
	input  logic [37:0]       base_q,
	input  logic [37:0]       limit_q,
	input  logic [1:0]        opcode,
	input  logic [37:0]       address,
	input  logic signed [31:0] size_bytes,
	input  logic [2:0]        protection,
	input  logic [1:0]        mode_bits,
	input  logic [3:0]        file_id,
	input  logic              file_open,
	input  logic              file_writable,
	input  logic signed [31:0] file_offset,
	output logic              result_valid,
	output logic [3:0]        status,
	output logic [37:0]       region_address,
	output logic [3:0]        slot_index,
	output logic [30:0]       region_size,
	output logic [2:0]        region_protection,
	output logic [1:0]        region_mode,
	output logic [3:0]        region_file,
	output logic [30:0]       region_file_offset,
	output logic              release_file,
	output logic [19:0]       pages_to_unmap
);
	import mrt_pkg::*;

	localparam logic [ADDR_W-1:0] PMASK = ADDR_W'((64'd1 << PAGE_BITS) - 64'd1);

	// slot table, cleared by reset (16 entries in flops)
	logic [SLOT_COUNT-1:0] valid_q;
	logic [ADDR_W-1:0] start_q [SLOT_COUNT];
	logic [LEN_W-1:0]  size_q  [SLOT_COUNT];
	logic [2:0]        prot_q  [SLOT_COUNT];
	logic [1:0]        mode_q  [SLOT_COUNT];
	logic [3:0]        file_q  [SLOT_COUNT];
	logic [LEN_W-1:0]  off_q   [SLOT_COUNT];

	// latched request
	logic [1:0]  op_q;
	logic [37:0] addr_q;
	logic [31:0] len_q;
	logic [2:0]  rprot_q;
	logic [1:0]  rmode_q;
	logic [3:0]  rfile_q;
	logic [31:0] roff_q;
	logic [3:0]  pre_st_q;

	// scan trackers
	logic                 free_hit_q, find_hit_q;
	logic [SLOT_BITS-1:0] free_idx_q, find_idx_q;
	logic [ADDR_W:0]      top_q;

	logic [3:0] pre_st;
	always_comb begin
		logic writeshare;
		writeshare = protection[1] & mode_bits[0] & ~file_writable;
		pre_st = ST_OK;
		unique case (opcode)
			OP_MAP: begin
				if (size_bytes[31] || file_offset[31] ||
				    (file_offset[PAGE_BITS-1:0] != '0)) pre_st = ST_BAD_ARG;
				else if ((32'(file_id) >= 32'(FILE_SLOTS)) || !file_open) pre_st = ST_NO_FILE;
				else if (writeshare) pre_st = ST_NOT_WR;
				else if (protection[2]) pre_st = ST_EXEC;
				else if (mode_bits == 2'd0) pre_st = ST_NO_MODE;
			end
			OP_FIND: pre_st = ST_OK;
			OP_UNMAP: begin
				if ((size_bytes == 32'sd0) || size_bytes[31] ||
				    ((address & PMASK) != '0) || (address < base_q) ||
				    (address >= limit_q)) pre_st = ST_BAD_ARG;
			end
			default: pre_st = ST_BAD_ARG;
		endcase
	end

	assign stat.precheck_fail = (pre_st_q != ST_OK);

	// per slot step
	logic [ADDR_W:0] s_end;
	logic            s_cover;
	assign s_end   = {1'b0, start_q[scan_idx]} + (ADDR_W+1)'(size_q[scan_idx]);
	assign s_cover = valid_q[scan_idx] && (start_q[scan_idx] <= addr_q) &&
	                 ({1'b0, addr_q} < s_end);

	// finish stage combinational
	logic [ADDR_W:0] at_rnd;
	logic [ADDR_W+1:0] at_end;
	assign at_rnd = (top_q + (ADDR_W+1)'(PMASK)) & ~(ADDR_W+1)'(PMASK);
	assign at_end = {1'b0, at_rnd} + (ADDR_W+2)'(len_q);

	logic [SLOT_BITS-1:0] f;
	logic [ADDR_W-1:0] fs;
	logic [LEN_W-1:0]  fz, fo;
	logic [ADDR_W:0]   a_plus_l, f_end;
	logic [LEN_W:0]    off_sum;
	assign f  = find_idx_q;
	assign fs = start_q[f];
	assign fz = size_q[f];
	assign fo = off_q[f];
	assign a_plus_l = {1'b0, addr_q} + (ADDR_W+1)'(len_q);
	assign f_end    = {1'b0, fs} + (ADDR_W+1)'(fz);
	assign off_sum  = {1'b0, fo} + len_q[LEN_W:0];

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			op_q <= opcode; addr_q <= address; len_q <= size_bytes;
			rprot_q <= protection; rmode_q <= mode_bits; rfile_q <= file_id;
			roff_q <= file_offset; pre_st_q <= pre_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				start_q[i] <= '0; size_q[i] <= '0; prot_q[i] <= '0;
				mode_q[i] <= '0; file_q[i] <= '0; off_q[i] <= '0;
			end
			free_hit_q <= 1'b0; find_hit_q <= 1'b0;
			free_idx_q <= '0; find_idx_q <= '0; top_q <= '0;
			result_valid <= 1'b0;
			status <= '0; region_address <= '0; slot_index <= '0;
			region_size <= '0; region_protection <= '0; region_mode <= '0;
			region_file <= '0; region_file_offset <= '0; release_file <= 1'b0;
			pages_to_unmap <= '0;
		end else begin
			result_valid <= 1'b0;
			if (cmd.clear) begin
				free_hit_q <= 1'b0; find_hit_q <= 1'b0;
				free_idx_q <= '0; find_idx_q <= '0;
				top_q <= {1'b0, base_q};
			end
			if (cmd.scan) begin
				if (!valid_q[scan_idx] && !free_hit_q) begin
					free_hit_q <= 1'b1; free_idx_q <= scan_idx;
				end
				if (s_cover && !find_hit_q) begin
					find_hit_q <= 1'b1; find_idx_q <= scan_idx;
				end
				if (valid_q[scan_idx] && (s_end > top_q)) top_q <= s_end;
			end
			if (cmd.finish) begin
				logic [3:0] st;
				result_valid <= 1'b1;
				st = pre_st_q;
				status <= '0; region_address <= '0; slot_index <= '0;
				region_size <= '0; region_protection <= '0; region_mode <= '0;
				region_file <= '0; region_file_offset <= '0; release_file <= 1'b0;
				pages_to_unmap <= '0;
				if (st == ST_OK) begin
					unique case (op_q)
						OP_MAP: begin
							if (!free_hit_q) st = ST_FULL;
							else if (at_end >= (ADDR_W+2)'(limit_q)) st = ST_NO_SPACE;
							else begin
								valid_q[free_idx_q] <= 1'b1;
								start_q[free_idx_q] <= at_rnd[ADDR_W-1:0];
								size_q[free_idx_q]  <= len_q[LEN_W-1:0];
								prot_q[free_idx_q]  <= rprot_q;
								mode_q[free_idx_q]  <= rmode_q;
								file_q[free_idx_q]  <= rfile_q;
								off_q[free_idx_q]   <= roff_q[LEN_W-1:0];
								region_address <= at_rnd[ADDR_W-1:0];
								slot_index <= 4'(free_idx_q);
								region_size <= len_q[LEN_W-1:0];
								region_protection <= rprot_q;
								region_mode <= rmode_q;
								region_file <= rfile_q;
								region_file_offset <= roff_q[LEN_W-1:0];
							end
						end
						OP_FIND: begin
							if (!find_hit_q) st = ST_NOT_FOUND;
							else begin
								region_address <= fs; slot_index <= 4'(f);
								region_size <= fz; region_protection <= prot_q[f];
								region_mode <= mode_q[f]; region_file <= file_q[f];
								region_file_offset <= fo;
							end
						end
						OP_UNMAP: begin
							if (!find_hit_q) st = ST_NOT_FOUND;
							else if (addr_q == fs && len_q[LEN_W-1:0] > fz) st = ST_BAD_ARG;
							else if (addr_q != fs && a_plus_l != f_end) st = ST_MIDDLE;
							else begin
								slot_index <= 4'(f);
								region_protection <= prot_q[f];
								region_mode <= mode_q[f];
								region_file <= file_q[f];
								pages_to_unmap <= 20'(((len_q - 32'd1) >> PAGE_BITS) + 32'd1);
								if (addr_q == fs && len_q[LEN_W-1:0] == fz) begin
									valid_q[f] <= 1'b0; start_q[f] <= '0; size_q[f] <= '0;
									off_q[f] <= '0; prot_q[f] <= '0; mode_q[f] <= '0;
									file_q[f] <= '0;
									region_address <= fs; release_file <= 1'b1;
								end else if (addr_q == fs) begin
									start_q[f] <= a_plus_l[ADDR_W-1:0];
									size_q[f] <= fz - len_q[LEN_W-1:0];
									off_q[f] <= off_sum[LEN_W] ? '1 : off_sum[LEN_W-1:0];
									region_address <= a_plus_l[ADDR_W-1:0];
									region_size <= fz - len_q[LEN_W-1:0];
									region_file_offset <= off_sum[LEN_W] ? '1 : off_sum[LEN_W-1:0];
								end else begin
									size_q[f] <= fz - len_q[LEN_W-1:0];
									region_address <= fs;
									region_size <= fz - len_q[LEN_W-1:0];
									region_file_offset <= fo;
								end
							end
						end
						default: st = ST_BAD_ARG;
					endcase
				end
				status <= st;
				if (st != ST_OK) begin
					region_address <= '0; slot_index <= '0; region_size <= '0;
					region_protection <= '0; region_mode <= '0; region_file <= '0;
					region_file_offset <= '0; release_file <= 1'b0;
					pages_to_unmap <= '0;
				end
			end
		end
	end
endmodule

FILE: design/mapped_region_table.sv
// Mapped region table: 16-slot table of address regions (map/find/unmap).
// Each item passes load, a scan of every slot, finish and the result register;
// an item rejected by argument checks skips the scan. A new item is taken only
// when busy is low, once the previous item has reached the result register.
// Results show for one cycle on done; the receiver cannot stall.
// Reset (arst_n low) frees every slot and loads the default base and limit.
module mapped_region_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [37:0] cfg_data,
	input  logic [1:0]  opcode,
	input  logic [37:0] address,
	input  logic signed [31:0] size_bytes,
	input  logic [2:0]  protection,
	input  logic [1:0]  mode_bits,
	input  logic [3:0]  file_id,
	input  logic        file_open,
	input  logic        file_writable,
	input  logic signed [31:0] file_offset,
	output logic        done,
	output logic [3:0]  status,
	output logic [37:0] region_address,
	output logic [3:0]  slot_index,
	output logic [30:0] region_size,
	output logic [2:0]  region_protection,
	output logic [1:0]  region_mode,
	output logic [3:0]  region_file,
	output logic [30:0] region_file_offset,
	output logic        release_file,
	output logic [19:0] pages_to_unmap
);
	import mrt_pkg::*;

	logic [37:0] base_q, limit_q;
	mrt_cmd_t  cmd;
	mrt_stat_t stat;
	logic [SLOT_BITS-1:0] scan_idx;

	// config word always accepted; user must write it only while idle (not enforced here)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= 38'h20_0000_0000;
			limit_q <= 38'h3F_FFFF_E000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data;
				CFG_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .cmd(cmd), .scan_idx(scan_idx)
	);

	mrt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .scan_idx(scan_idx),
		.base_q(base_q), .limit_q(limit_q),
		.opcode(opcode), .address(address), .size_bytes(size_bytes),
		.protection(protection), .mode_bits(mode_bits), .file_id(file_id),
		.file_open(file_open), .file_writable(file_writable),
		.file_offset(file_offset),
		.result_valid(done), .status(status), .region_address(region_address),
		.slot_index(slot_index), .region_size(region_size),
		.region_protection(region_protection), .region_mode(region_mode),
		.region_file(region_file), .region_file_offset(region_file_offset),
		.release_file(release_file), .pages_to_unmap(pages_to_unmap)
	);
endmodule

FILE: dv/mrt_checker.sv
module mrt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [37:0] cfg_data,
	input  logic [1:0]  opcode,
	input  logic [37:0] address,
	input  logic signed [31:0] size_bytes,
	input  logic [2:0]  protection,
	input  logic [1:0]  mode_bits,
	input  logic [3:0]  file_id,
	input  logic        file_open,
	input  logic        file_writable,
	input  logic signed [31:0] file_offset,
	input  logic        done,
	input  logic [3:0]  status,
	input  logic [37:0] region_address,
	input  logic [3:0]  slot_index,
	input  logic [30:0] region_size,
	input  logic [2:0]  region_protection,
	input  logic [1:0]  region_mode,
	input  logic [3:0]  region_file,
	input  logic [30:0] region_file_offset,
	input  logic        release_file,
	input  logic [19:0] pages_to_unmap,
	output int          errors,
	output int          outstanding
);
	import mrt_pkg::*;

	typedef struct packed {
		logic [3:0]  st;
		logic [37:0] addr;
		logic [3:0]  slot;
		logic [30:0] size;
		logic [2:0]  prot;
		logic [1:0]  mode;
		logic [3:0]  file;
		logic [30:0] off;
		logic        rel;
		logic [19:0] pages;
	} region_word_t;

	localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_BITS) - 64'd1;
	localparam logic [63:0] OFF_MAX   = (64'd1 << LEN_W) - 64'd1;

	logic [37:0] base_q, limit_q;
	logic        used_q  [SLOT_COUNT];
	logic [63:0] start_q [SLOT_COUNT];
	logic [63:0] size_q  [SLOT_COUNT];
	logic [2:0]  prot_q  [SLOT_COUNT];
	logic [1:0]  mode_q  [SLOT_COUNT];
	logic [3:0]  file_q  [SLOT_COUNT];
	logic [63:0] off_q   [SLOT_COUNT];

	region_word_t expected_words[$];

	assign outstanding = expected_words.size();

	function automatic region_word_t fail_word(logic [3:0] st);
		region_word_t w;
		w = '0;
		w.st = st;
		return w;
	endfunction

	function automatic int covering_slot(logic [63:0] a);
		for (int i = 0; i < SLOT_COUNT; i++)
			if (used_q[i] && start_q[i] <= a && a < start_q[i] + size_q[i])
				return i;
		return -1;
	endfunction

	task automatic region_result(input int s, input logic [63:0] addr, output region_word_t w);
		w = '0;
		w.st   = ST_OK;
		w.addr = addr[37:0];
		w.slot = s[3:0];
		w.size = size_q[s][30:0];
		w.prot = prot_q[s];
		w.mode = mode_q[s];
		w.file = file_q[s];
		w.off  = off_q[s][30:0];
	endtask

	// updates the shadow table and returns the word the block should give
	task automatic table_step(output region_word_t w);
		logic [63:0] sz, off, at, a, len;
		int          s;
		sz  = {32'd0, size_bytes};
		off = {32'd0, file_offset};
		a   = {26'd0, address};
		len = sz;
		s   = -1;
		case (opcode)
			OP_MAP: begin
				if (sz[31] || off[31] || (off & PAGE_MASK) != 0)
					w = fail_word(ST_BAD_ARG);
				else if (file_id >= FILE_SLOTS || !file_open)
					w = fail_word(ST_NO_FILE);
				else if (protection[1] && mode_bits[0] && !file_writable)
					w = fail_word(ST_NOT_WR);
				else if (protection[2])
					w = fail_word(ST_EXEC);
				else if (mode_bits == 2'b00)
					w = fail_word(ST_NO_MODE);
				else begin
					for (int i = SLOT_COUNT - 1; i >= 0; i--)
						if (!used_q[i])
							s = i;
					at = {26'd0, base_q};
					for (int i = 0; i < SLOT_COUNT; i++)
						if (used_q[i] && start_q[i] + size_q[i] > at)
							at = start_q[i] + size_q[i];
					at = (at + PAGE_MASK) & ~PAGE_MASK;
					if (s < 0)
						w = fail_word(ST_FULL);
					else if (at + sz >= {26'd0, limit_q})
						w = fail_word(ST_NO_SPACE);
					else begin
						used_q[s]  = 1'b1;
						start_q[s] = at;
						size_q[s]  = sz;
						prot_q[s]  = protection;
						mode_q[s]  = mode_bits;
						file_q[s]  = file_id;
						off_q[s]   = off;
						region_result(s, at, w);
					end
				end
			end
			OP_FIND: begin
				s = covering_slot(a);
				if (s < 0)
					w = fail_word(ST_NOT_FOUND);
				else
					region_result(s, start_q[s], w);
			end
			OP_UNMAP: begin
				if (len == 0 || len[31] || (a & PAGE_MASK) != 0 || a < {26'd0, base_q} ||
						a >= {26'd0, limit_q})
					w = fail_word(ST_BAD_ARG);
				else begin
					s = covering_slot(a);
					if (s < 0)
						w = fail_word(ST_NOT_FOUND);
					else if (a == start_q[s] && len > size_q[s])
						w = fail_word(ST_BAD_ARG);
					else if (a == start_q[s] && len == size_q[s]) begin
						// whole region goes; report it, then free the slot
						size_q[s] = 0;
						off_q[s]  = 0;
						region_result(s, start_q[s], w);
						w.rel     = 1'b1;
						used_q[s]  = 1'b0;
						start_q[s] = 0;
						prot_q[s]  = '0;
						mode_q[s]  = '0;
						file_q[s]  = '0;
					end else if (a == start_q[s]) begin
						start_q[s] += len;
						size_q[s]  -= len;
						off_q[s]   += len;
						if (off_q[s] > OFF_MAX)
							off_q[s] = OFF_MAX;
						region_result(s, start_q[s], w);
					end else if (a + len == start_q[s] + size_q[s]) begin
						size_q[s] -= len;
						region_result(s, start_q[s], w);
					end else
						w = fail_word(ST_MIDDLE);
					if (w.st == ST_OK)
						w.pages = 20'(((len - 1) >> PAGE_BITS) + 1);
				end
			end
			default: w = fail_word(ST_BAD_ARG);
		endcase
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		region_word_t w;
		if (!arst_n) begin
			base_q  <= 38'h2000000000;
			limit_q <= 38'h3FFFFFE000;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				used_q[i]  = 1'b0;
				start_q[i] = 0;
				size_q[i]  = 0;
				prot_q[i]  = '0;
				mode_q[i]  = '0;
				file_q[i]  = '0;
				off_q[i]   = 0;
			end
			expected_words.delete();
			errors = 0;
		end else begin
			if (done) begin
				if (expected_words.size() == 0)
					report("unexpected word", 1, 0);
				else begin
					w = expected_words.pop_front();
					if (status !== w.st) report("status", status, w.st);
					if (region_address !== w.addr) report("region_address", region_address, w.addr);
					if (slot_index !== w.slot) report("slot_index", slot_index, w.slot);
					if (region_size !== w.size) report("region_size", region_size, w.size);
					if (region_protection !== w.prot)
						report("region_protection", region_protection, w.prot);
					if (region_mode !== w.mode) report("region_mode", region_mode, w.mode);
					if (region_file !== w.file) report("region_file", region_file, w.file);
					if (region_file_offset !== w.off)
						report("region_file_offset", region_file_offset, w.off);
					if (release_file !== w.rel) report("release_file", release_file, w.rel);
					if (pages_to_unmap !== w.pages)
						report("pages_to_unmap", pages_to_unmap, w.pages);
				end
			end
			if (start && !busy) begin
				table_step(w);
				expected_words.push_back(w);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BASE)
					base_q <= cfg_data;
				else
					limit_q <= cfg_data;
			end
		end
	end
endmodule

FILE: dv/mapped_region_table_test.sv
module mapped_region_table_test;
	import mrt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [37:0] cfg_data;
	logic [1:0]  opcode;
	logic [37:0] address;
	logic signed [31:0] size_bytes;
	logic [2:0]  protection;
	logic [1:0]  mode_bits;
	logic [3:0]  file_id;
	logic        file_open;
	logic        file_writable;
	logic signed [31:0] file_offset;
	logic        done;
	logic [3:0]  status;
	logic [37:0] region_address;
	logic [3:0]  slot_index;
	logic [30:0] region_size;
	logic [2:0]  region_protection;
	logic [1:0]  region_mode;
	logic [3:0]  region_file;
	logic [30:0] region_file_offset;
	logic        release_file;
	logic [19:0] pages_to_unmap;
	int          errors;
	int          outstanding;

	localparam logic [37:0] PAGE = 38'd1 << PAGE_BITS;
	localparam logic [37:0] B0   = 38'h2000000000;   // base after reset

	// live regions seen in good words, used to aim unmaps and finds
	logic [37:0] known_start[$];
	logic [30:0] known_size[$];

	mapped_region_table i_dut (.*);

	mrt_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (done && status == ST_OK && region_size != 0) begin
			known_start.push_back(region_address);
			known_size.push_back(region_size);
			if (known_start.size() > 24) begin
				void'(known_start.pop_front());
				void'(known_size.pop_front());
			end
		end
	end

	// hold start high until the word is taken; busy is steady between rising edges
	task automatic issue(input logic [1:0] op, input logic [37:0] a, input logic [31:0] sz,
			input logic [2:0] pr, input logic [1:0] md, input logic [3:0] fid,
			input logic op_en, input logic wr, input logic [31:0] off);
		logic taken;
		opcode        <= op;
		address       <= a;
		size_bytes    <= sz;
		protection    <= pr;
		mode_bits     <= md;
		file_id       <= fid;
		file_open     <= op_en;
		file_writable <= wr;
		file_offset   <= off;
		start         <= 1'b1;
		do begin
			taken = !busy;
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic map_ok(input logic [31:0] sz);
		issue(OP_MAP, $urandom, sz, 3'b011, 2'b01, 4'd3, 1'b1, 1'b1, 32'h2000);
	endtask

	task automatic unmap(input logic [37:0] a, input logic [31:0] len);
		issue(OP_UNMAP, a, len, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic find(input logic [37:0] a);
		issue(OP_FIND, a, $urandom, 0, 0, 0, 0, 0, 0);
	endtask

	// only while idle: drain, then let a rejected item finish too
	task automatic write_reg(input logic idx, input logic [37:0] value);
		logic taken;
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do begin
			taken = cfg_ready;
			@(negedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_item();
		logic [37:0] a, s;
		logic [31:0] len;
		int          k, pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			case ($urandom_range(0, 9))
				0:       len = $urandom_range(0, 32'h3000);
				1:       len = $urandom;
				2:       len = 32'h7FFFFFFF;
				default: len = PAGE * $urandom_range(1, 8);
			endcase
			issue(OP_MAP, {$urandom, $urandom},
				len,
				($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3)),
				($urandom_range(0, 9) == 0) ? 2'b00 : 2'($urandom_range(1, 3)),
				4'($urandom),
				$urandom_range(0, 15) != 0,
				1'($urandom),
				($urandom_range(0, 7) == 0) ? $urandom : {20'($urandom_range(0, 255)), 12'd0});
		end else if (pick < 88 && known_start.size() != 0) begin
			k = $urandom_range(0, known_start.size() - 1);
			a = known_start[k];
			s = known_size[k];
			case ($urandom_range(0, 5))
				0: find(a + $urandom_range(0, s - 1));
				1: unmap(a, s);                                  // free whole
				2: unmap(a, PAGE * $urandom_range(1, 3));        // trim start
				3: begin                                         // trim end
					len = PAGE * $urandom_range(1, 3);
					unmap(a + s - len, len);
				end
				4: unmap(a + PAGE, PAGE);                        // middle or end
				default: unmap(a, s + PAGE);                     // too long
			endcase
		end else begin
			// noise
			issue(2'($urandom), {$urandom, $urandom}, $urandom, 3'($urandom), 2'($urandom),
				4'($urandom), 1'($urandom), 1'($urandom), $urandom);
		end
		// sender bursts: occasional gaps of random length
		if ($urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
	endtask

	initial begin
		start         = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_BASE;
		cfg_data      = '0;
		opcode        = OP_FIND;
		address       = '0;
		size_bytes    = '0;
		protection    = '0;
		mode_bits     = '0;
		file_id       = '0;
		file_open     = 1'b0;
		file_writable = 1'b0;
		file_offset   = '0;
		arst_n        = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: map argument checks in priority order
		issue(OP_MAP, 0, 32'h80000000, 3'b001, 2'b01, 4'd0, 1'b1, 1'b1, 0);  // negative size
		issue(OP_MAP, 0, PAGE, 3'b001, 2'b01, 4'd0, 1'b1, 1'b1, 32'h80000000); // negative offset
		issue(OP_MAP, 0, PAGE, 3'b001, 2'b01, 4'd0, 1'b1, 1'b1, 32'h00000801); // unaligned offset
		issue(OP_MAP, 0, PAGE, 3'b001, 2'b01, 4'd15, 1'b0, 1'b1, 0);          // file not open
		issue(OP_MAP, 0, PAGE, 3'b010, 2'b01, 4'd1, 1'b1, 1'b0, 0);           // shared write, ro file
		issue(OP_MAP, 0, PAGE, 3'b111, 2'b10, 4'd1, 1'b1, 1'b1, 0);           // exec
		issue(OP_MAP, 0, PAGE, 3'b001, 2'b00, 4'd1, 1'b1, 1'b1, 0);           // no mode
		issue(OP_MAP, 0, 32'h4000, 3'b011, 2'b10, 4'd2, 1'b1, 1'b0, 32'h7FFFF000); // slot 0 at base
		map_ok(0);                                                            // zero size map
		find(B0 + 38'h10);
		find(0);
		find(38'h3FFFFFFFFF);
		unmap(B0, 0);                 // zero length
		unmap(B0, 32'hFFFFF000);      // negative length
		unmap(B0 + 38'h10, PAGE);     // unaligned
		unmap(PAGE, PAGE);            // below base
		unmap(38'h3FFFFFE000, PAGE);  // at limit
		unmap(B0 + 38'h10000, PAGE);  // nothing there
		unmap(B0 + PAGE, PAGE);       // middle cut
		unmap(B0, 32'h10000);         // longer than region
		unmap(B0, PAGE);              // start trim, offset saturates
		unmap(B0 + 38'h3000, PAGE);   // end trim
		unmap(B0 + PAGE, 32'h2000);   // rest freed whole
		issue(2'd3, 0, 0, 0, 0, 0, 0, 0, 0);   // unknown opcode
		for (int i = 0; i < SLOT_COUNT + 1; i++)
			map_ok(PAGE);             // last two find the table full

		// random phases across register settings, extremes included
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin
					write_reg(CFG_BASE, 38'd1);
					write_reg(CFG_LIMIT, 38'h3FFFFFFFFF);
				end
				2: write_reg(CFG_BASE, 38'h3FFFFF0000);
				3: begin
					write_reg(CFG_BASE, 38'h100000);
					write_reg(CFG_LIMIT, 38'h140000);
				end
				4: begin
					write_reg(CFG_BASE, B0);
					write_reg(CFG_LIMIT, 38'd1);
					write_reg(CFG_LIMIT, 38'h3FFFFFE000);
				end
				default: ;
			endcase
			for (int n = 0; n < 245; n++)
				random_item();
		end
		start <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
